/* hw/rtl/qmva_pkg.sv */
package qmva_pkg;

   // job length limits and the counter widths that follow from them
   localparam int MAX_IN_LEN   = 4096;
   localparam int MAX_BATCH    = 256;
   localparam int MAX_OUT_ROWS = 4096;

   localparam int ELEM_W  = $clog2(MAX_IN_LEN);
   localparam int LEN_W   = ELEM_W + 1;
   localparam int BATCH_W = $clog2(MAX_BATCH);
   localparam int NB_W    = BATCH_W + 1;
   localparam int ROW_W   = $clog2(MAX_OUT_ROWS);
   localparam int NR_W    = ROW_W + 1;

   // register field widths
   localparam int IN_LEN_W     = 13;
   localparam int BATCH_ROWS_W = 9;
   localparam int OUT_START_W  = 12;
   localparam int OUT_COUNT_W  = 13;
   localparam int OUT_STRIDE_W = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int ACC_W   = 48;
   localparam int PROD_W  = 64;
   localparam int MAG_W   = 40;
   localparam int INDEX_W = 20;
   localparam int WROW_W  = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_FORMAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_LEN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_ROWS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_START      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_STRIDE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALES_PRESENT = 3'd6;

   localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

   typedef enum logic [1:0] {
      FMT_Q412   = 2'd0,
      FMT_INT8   = 2'd1,
      FMT_NIB4   = 2'd2,
      FMT_CRUMB2 = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_MUL,
      ST_RND,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic signed [15:0] activation;
      logic [15:0]        weight_word;
      logic signed [15:0] weight_scale;
   } req_type;

   typedef struct packed {
      logic signed [31:0] dot_result;
      logic [INDEX_W-1:0] result_index;
      logic [WROW_W-1:0]  weight_row;
      logic               saturated;
      logic               job_done;
   } rsp_type;

   // effective job setup, lengths already clamped
   typedef struct packed {
      fmt_type                 fmt;
      logic [LEN_W-1:0]        len;
      logic [NB_W-1:0]         nb;
      logic [NR_W-1:0]         nr;
      logic [OUT_START_W-1:0]  out_start;
      logic [OUT_STRIDE_W-1:0] out_stride;
      logic                    scales_present;
   } cfg_type;

   typedef struct packed {
      logic mac;
      logic finish;
      logic mul;
      logic rnd;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic last_element;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/qmva_csr.sv */
module qmva_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [qmva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qmva_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output qmva_pkg::cfg_type                cfg
);

   qmva_pkg::fmt_type                       fmt_ff, fmt_in;
   logic [qmva_pkg::IN_LEN_W-1:0]           in_len_ff, in_len_in;
   logic [qmva_pkg::BATCH_ROWS_W-1:0]       batch_rows_ff, batch_rows_in;
   logic [qmva_pkg::OUT_START_W-1:0]        out_start_ff, out_start_in;
   logic [qmva_pkg::OUT_COUNT_W-1:0]        out_count_ff, out_count_in;
   logic [qmva_pkg::OUT_STRIDE_W-1:0]       out_stride_ff, out_stride_in;
   logic                                    scales_ff, scales_in;

   always_comb begin
      fmt_in        = fmt_ff;
      in_len_in     = in_len_ff;
      batch_rows_in = batch_rows_ff;
      out_start_in  = out_start_ff;
      out_count_in  = out_count_ff;
      out_stride_in = out_stride_ff;
      scales_in     = scales_ff;
      if (csr_we) begin
         case (csr_index)
            qmva_pkg::CSR_WEIGHT_FORMAT:
               fmt_in = qmva_pkg::fmt_type'(csr_wdata[1:0]);
            qmva_pkg::CSR_IN_LEN:
               in_len_in = csr_wdata[qmva_pkg::IN_LEN_W-1:0];
            qmva_pkg::CSR_BATCH_ROWS:
               batch_rows_in = csr_wdata[qmva_pkg::BATCH_ROWS_W-1:0];
            qmva_pkg::CSR_OUT_START:
               out_start_in = csr_wdata[qmva_pkg::OUT_START_W-1:0];
            qmva_pkg::CSR_OUT_COUNT:
               out_count_in = csr_wdata[qmva_pkg::OUT_COUNT_W-1:0];
            qmva_pkg::CSR_OUT_STRIDE:
               out_stride_in = csr_wdata[qmva_pkg::OUT_STRIDE_W-1:0];
            qmva_pkg::CSR_SCALES_PRESENT:
               scales_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= qmva_pkg::FMT_Q412;
         in_len_ff     <= qmva_pkg::IN_LEN_W'(1);
         batch_rows_ff <= qmva_pkg::BATCH_ROWS_W'(1);
         out_start_ff  <= '0;
         out_count_ff  <= qmva_pkg::OUT_COUNT_W'(1);
         out_stride_ff <= qmva_pkg::OUT_STRIDE_W'(1);
         scales_ff     <= 1'b1;
      end else begin
         fmt_ff        <= fmt_in;
         in_len_ff     <= in_len_in;
         batch_rows_ff <= batch_rows_in;
         out_start_ff  <= out_start_in;
         out_count_ff  <= out_count_in;
         out_stride_ff <= out_stride_in;
         scales_ff     <= scales_in;
      end
   end

   // zero acts as one, anything above the limit acts as the limit
   always_comb begin
      cfg.fmt            = fmt_ff;
      cfg.out_start      = out_start_ff;
      cfg.out_stride     = out_stride_ff;
      cfg.scales_present = scales_ff;

      if (in_len_ff == '0)
         cfg.len = qmva_pkg::LEN_W'(1);
      else if (in_len_ff > qmva_pkg::IN_LEN_W'(qmva_pkg::MAX_IN_LEN))
         cfg.len = qmva_pkg::LEN_W'(qmva_pkg::MAX_IN_LEN);
      else
         cfg.len = qmva_pkg::LEN_W'(in_len_ff);

      if (batch_rows_ff == '0)
         cfg.nb = qmva_pkg::NB_W'(1);
      else if (batch_rows_ff > qmva_pkg::BATCH_ROWS_W'(qmva_pkg::MAX_BATCH))
         cfg.nb = qmva_pkg::NB_W'(qmva_pkg::MAX_BATCH);
      else
         cfg.nb = qmva_pkg::NB_W'(batch_rows_ff);

      if (out_count_ff == '0)
         cfg.nr = qmva_pkg::NR_W'(1);
      else if (out_count_ff > qmva_pkg::OUT_COUNT_W'(qmva_pkg::MAX_OUT_ROWS))
         cfg.nr = qmva_pkg::NR_W'(qmva_pkg::MAX_OUT_ROWS);
      else
         cfg.nr = qmva_pkg::NR_W'(out_count_ff);
   end

endmodule

/* hw/rtl/qmva_ctrl.sv */
module qmva_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qmva_pkg::status_type status,
   output qmva_pkg::cmd_type    cmd
);

   qmva_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qmva_pkg::ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         qmva_pkg::ST_ACCEPT: begin
            req_ready  = 1'b1;
            cmd.mac    = req_valid;
            cmd.finish = req_valid && status.last_element;
            if (req_valid && status.last_element) begin
               state_in = qmva_pkg::ST_MUL;
            end
         end
         qmva_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = qmva_pkg::ST_RND;
         end
         qmva_pkg::ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = qmva_pkg::ST_SAT;
         end
         qmva_pkg::ST_SAT: begin
            // hold the finished value until the output register can take it
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = qmva_pkg::ST_ACCEPT;
            end
         end
         default: begin
            state_in = qmva_pkg::ST_ACCEPT;
         end
      endcase
   end

endmodule

/* hw/rtl/qmva_dp.sv */
module qmva_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  qmva_pkg::cfg_type    cfg,
   input  qmva_pkg::cmd_type    cmd,
   output qmva_pkg::status_type status,
   input  qmva_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qmva_pkg::rsp_type    rsp_data
);

   logic signed [qmva_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [qmva_pkg::ELEM_W-1:0]         elem_ff, elem_in;
   logic [qmva_pkg::BATCH_W-1:0]        batch_ff, batch_in;
   logic [qmva_pkg::ROW_W-1:0]          row_ff, row_in;

   logic signed [qmva_pkg::ACC_W-1:0]   sum_ff, sum_in;
   logic signed [15:0]                  scale_ff, scale_in;
   logic [qmva_pkg::BATCH_W-1:0]        pend_batch_ff, pend_batch_in;
   logic [qmva_pkg::ROW_W-1:0]          pend_row_ff, pend_row_in;
   logic                                pend_done_ff, pend_done_in;

   logic signed [qmva_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [qmva_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic [qmva_pkg::WROW_W-1:0]         wrow_ff, wrow_in;

   logic                                neg_ff, neg_in;
   logic [qmva_pkg::MAG_W-1:0]          mag_ff, mag_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   qmva_pkg::rsp_type                   rsp_ff, rsp_in;

   logic signed [15:0]                  wval;
   logic [3:0]                          nib;
   logic [1:0]                          crumb;
   logic signed [31:0]                  elem_prod;
   logic signed [qmva_pkg::ACC_W-1:0]   term;
   logic                                batch_last;
   logic                                row_last;
   logic [qmva_pkg::PROD_W-1:0]         abs_prod;
   logic [qmva_pkg::PROD_W-1:0]         rnd_sum;
   logic [20:0]                         index_full;
   logic                                sat;
   logic signed [31:0]                  q;

   // weight decode, the element index picks the packed field
   always_comb begin
      nib   = elem_ff[0] ? req_data.weight_word[7:4] : req_data.weight_word[3:0];
      case (elem_ff[1:0])
         2'd0:    crumb = req_data.weight_word[1:0];
         2'd1:    crumb = req_data.weight_word[3:2];
         2'd2:    crumb = req_data.weight_word[5:4];
         default: crumb = req_data.weight_word[7:6];
      endcase
      case (cfg.fmt)
         qmva_pkg::FMT_Q412:
            wval = $signed(req_data.weight_word);
         qmva_pkg::FMT_INT8:
            wval = $signed({{8{req_data.weight_word[7]}}, req_data.weight_word[7:0]});
         qmva_pkg::FMT_NIB4:
            wval = $signed({12'b0, nib}) - 16'sd8;
         default:
            wval = $signed({14'b0, crumb}) - 16'sd2;
      endcase
      elem_prod = req_data.activation * wval;
      // integer formats carry the weight as an integer, bring it to Q.24
      if (cfg.fmt == qmva_pkg::FMT_Q412)
         term = {{16{elem_prod[31]}}, elem_prod};
      else
         term = {{4{elem_prod[31]}}, elem_prod, 12'b0};
   end

   assign status.last_element =
      ({1'b0, elem_ff} + qmva_pkg::LEN_W'(1)) >= cfg.len;
   assign batch_last = ({1'b0, batch_ff} + qmva_pkg::NB_W'(1)) >= cfg.nb;
   assign row_last   = ({1'b0, row_ff} + qmva_pkg::NR_W'(1)) >= cfg.nr;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign abs_prod   = prod_ff[qmva_pkg::PROD_W-1] ? -prod_ff : prod_ff;
   assign rnd_sum    = abs_prod + qmva_pkg::PROD_W'(64'h80_0000);
   assign index_full = {13'b0, pend_batch_ff} * {8'b0, cfg.out_stride}
                       + {9'b0, pend_row_ff};

   // saturate the rounded magnitude to the signed 32-bit range
   always_comb begin
      if (neg_ff) begin
         sat = mag_ff > qmva_pkg::MAG_W'(40'h80000000);
         q   = sat ? 32'sh80000000 : -$signed(mag_ff[31:0]);
      end else begin
         sat = mag_ff > qmva_pkg::MAG_W'(40'h7fffffff);
         q   = sat ? 32'sh7fffffff : $signed(mag_ff[31:0]);
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      elem_in       = elem_ff;
      batch_in      = batch_ff;
      row_in        = row_ff;
      sum_in        = sum_ff;
      scale_in      = scale_ff;
      pend_batch_in = pend_batch_ff;
      pend_row_in   = pend_row_ff;
      pend_done_in  = pend_done_ff;
      prod_in       = prod_ff;
      index_in      = index_ff;
      wrow_in       = wrow_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.mac) begin
         if (cmd.finish) begin
            acc_in        = '0;
            elem_in       = '0;
            sum_in        = acc_ff + term;
            scale_in      = (cfg.fmt != qmva_pkg::FMT_Q412 && cfg.scales_present)
                            ? req_data.weight_scale : qmva_pkg::ONE_Q12;
            pend_batch_in = batch_ff;
            pend_row_in   = row_ff;
            pend_done_in  = batch_last && row_last;
            if (batch_last) begin
               batch_in = '0;
               row_in   = row_last ? '0 : row_ff + qmva_pkg::ROW_W'(1);
            end else begin
               batch_in = batch_ff + qmva_pkg::BATCH_W'(1);
            end
         end else begin
            acc_in  = acc_ff + term;
            elem_in = elem_ff + qmva_pkg::ELEM_W'(1);
         end
      end

      if (cmd.mul) begin
         prod_in  = sum_ff * scale_ff;
         index_in = index_full[qmva_pkg::INDEX_W-1:0];
         wrow_in  = {1'b0, cfg.out_start} + {1'b0, pend_row_ff};
      end

      // round half away from zero on the magnitude
      if (cmd.rnd) begin
         neg_in = prod_ff[qmva_pkg::PROD_W-1];
         mag_in = rnd_sum[qmva_pkg::PROD_W-1:24];
      end

      if (cmd.load) begin
         rsp_in.dot_result   = q;
         rsp_in.result_index = index_ff;
         rsp_in.weight_row   = wrow_ff;
         rsp_in.saturated    = sat;
         rsp_in.job_done     = pend_done_ff;
         rsp_valid_in        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         elem_ff      <= '0;
         batch_ff     <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         elem_ff      <= elem_in;
         batch_ff     <= batch_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      scale_ff      <= scale_in;
      pend_batch_ff <= pend_batch_in;
      pend_row_ff   <= pend_row_in;
      pend_done_ff  <= pend_done_in;
      prod_ff       <= prod_in;
      index_ff      <= index_in;
      wrow_ff       <= wrow_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/quantized_matvec_accumulator.sv */
// Quantized matrix-vector accumulator. Each transfer on the req channel carries one
// activation, its weight word and the current row scale; the weight is decoded per
// weight_format and multiply-accumulated into a 48-bit Q.24 sum. Elements that do not
// end a dot product are taken one per cycle. The last element of a dot product passes
// through accumulate, scale multiply, round and saturate into the output register before
// the next transfer is accepted, and waits while the output register is still held by
// an untaken result; that scaling sequence sets the rate at row ends. One rsp transfer
// follows each completed dot product, with job_done set on the last one of the job.
// Configuration registers are written through csr_we/csr_index/csr_wdata and take
// effect immediately; write them only while no dot product is in flight.
module quantized_matvec_accumulator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  qmva_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output qmva_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [qmva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qmva_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   qmva_pkg::cfg_type    cfg;
   qmva_pkg::cmd_type    cmd;
   qmva_pkg::status_type status;

   qmva_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qmva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qmva_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a new result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending result");

   // the transfer that ends a dot product stalls the input for the scaling steps
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.last_element) |=> !req_ready)
      else $error("input accepted during scaling");

   // a clipped result sits at one of the two range limits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.dot_result == 32'sh7fffffff || rsp_data.dot_result == 32'sh80000000))
      else $error("saturated flag without a clipped value");

endmodule

/* dv/quantized_matvec_accumulator_tb.sv */
`timescale 1ns / 1ps

module quantized_matvec_accumulator_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS = 740;
   localparam int QUIET_ITEMS = 600;
   localparam logic [qmva_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam longint INT32_TOP = 64'sd2147483647;
   localparam longint INT32_BOTTOM = -64'sd2147483648;
   localparam longint HALF_LSB = 64'sd8388608;

   typedef struct packed {
      logic [1:0]                        fmt;
      logic [qmva_pkg::IN_LEN_W-1:0]     in_len;
      logic [qmva_pkg::BATCH_ROWS_W-1:0] batch_rows;
      logic [qmva_pkg::OUT_START_W-1:0]  out_start;
      logic [qmva_pkg::OUT_COUNT_W-1:0]  out_count;
      logic [qmva_pkg::OUT_STRIDE_W-1:0] out_stride;
      logic                              scales_present;
   } setup_type;

   class matvec_scoreboard;
      qmva_pkg::fmt_type                 fmt;
      logic [qmva_pkg::IN_LEN_W-1:0]     in_len;
      logic [qmva_pkg::BATCH_ROWS_W-1:0] batch_rows;
      logic [qmva_pkg::OUT_START_W-1:0]  out_start;
      logic [qmva_pkg::OUT_COUNT_W-1:0]  out_count;
      logic [qmva_pkg::OUT_STRIDE_W-1:0] out_stride;
      logic                              scales_on;
      logic [qmva_pkg::ACC_W-1:0]        acc;
      int unsigned                       elem;
      int unsigned                       batch;
      int unsigned                       row;
      qmva_pkg::rsp_type                 pending[$];
      int                                errors;

      function new();
         fmt = qmva_pkg::FMT_Q412;
         in_len = 1;
         batch_rows = 1;
         out_start = 0;
         out_count = 1;
         out_stride = 1;
         scales_on = 1'b1;
         acc = '0;
         elem = 0;
         batch = 0;
         row = 0;
         errors = 0;
      endfunction

      function int unsigned clamp_count(int unsigned v, int unsigned top);
         if (v == 0) return 1;
         return (v > top) ? top : v;
      endfunction

      function void write_reg(logic [qmva_pkg::CSR_IDX_W-1:0] idx,
                              logic [qmva_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            qmva_pkg::CSR_WEIGHT_FORMAT:  fmt = qmva_pkg::fmt_type'(val[1:0]);
            qmva_pkg::CSR_IN_LEN:         in_len = val[qmva_pkg::IN_LEN_W-1:0];
            qmva_pkg::CSR_BATCH_ROWS:     batch_rows = val[qmva_pkg::BATCH_ROWS_W-1:0];
            qmva_pkg::CSR_OUT_START:      out_start = val[qmva_pkg::OUT_START_W-1:0];
            qmva_pkg::CSR_OUT_COUNT:      out_count = val[qmva_pkg::OUT_COUNT_W-1:0];
            qmva_pkg::CSR_OUT_STRIDE:     out_stride = val[qmva_pkg::OUT_STRIDE_W-1:0];
            qmva_pkg::CSR_SCALES_PRESENT: scales_on = val[0];
            default: ;
         endcase
      endfunction

      // one accepted element; queues a result at the end of a dot product
      function void note_input(qmva_pkg::req_type d);
         longint act, wq, term, total, scale, prod, q, idx_sum;
         logic [3:0] nib;
         logic [1:0] crumb;
         int unsigned len, nb, nr;
         logic sat, done;
         qmva_pkg::rsp_type r;
         len = clamp_count(in_len, qmva_pkg::MAX_IN_LEN);
         nb = clamp_count(batch_rows, qmva_pkg::MAX_BATCH);
         nr = clamp_count(out_count, qmva_pkg::MAX_OUT_ROWS);
         act = longint'($signed(d.activation));
         case (fmt)
            qmva_pkg::FMT_Q412: wq = longint'($signed(d.weight_word));
            qmva_pkg::FMT_INT8: wq = longint'($signed(d.weight_word[7:0])) * 4096;
            qmva_pkg::FMT_NIB4: begin
               nib = (elem % 2 == 1) ? d.weight_word[7:4] : d.weight_word[3:0];
               wq = (longint'(nib) - 8) * 4096;
            end
            default: begin
               crumb = d.weight_word[(elem % 4) * 2 +: 2];
               wq = (longint'(crumb) - 2) * 4096;
            end
         endcase
         term = act * wq;
         acc = acc + term[qmva_pkg::ACC_W-1:0];
         if (elem + 1 < len) begin
            elem++;
            return;
         end
         total = longint'($signed(acc));
         scale = (fmt != qmva_pkg::FMT_Q412 && scales_on)
                 ? longint'($signed(d.weight_scale)) : 4096;
         prod = total * scale;
         // round half away from zero on the magnitude
         if (prod >= 0) q = (prod + HALF_LSB) >>> 24;
         else q = -((-prod + HALF_LSB) >>> 24);
         sat = 1'b0;
         if (q > INT32_TOP) begin
            q = INT32_TOP;
            sat = 1'b1;
         end
         if (q < INT32_BOTTOM) begin
            q = INT32_BOTTOM;
            sat = 1'b1;
         end
         idx_sum = longint'(batch) * longint'(out_stride) + longint'(row);
         r.dot_result = q[31:0];
         r.result_index = idx_sum[qmva_pkg::INDEX_W-1:0];
         idx_sum = longint'(out_start) + longint'(row);
         r.weight_row = idx_sum[qmva_pkg::WROW_W-1:0];
         r.saturated = sat;
         acc = '0;
         elem = 0;
         done = 1'b0;
         if (batch + 1 < nb) begin
            batch++;
         end else begin
            batch = 0;
            if (row + 1 < nr) begin
               row++;
            end else begin
               row = 0;
               done = 1'b1;
            end
         end
         r.job_done = done;
         pending.push_back(r);
      endfunction

      function void flag_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(qmva_pkg::rsp_type got);
         qmva_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: result %h arrived with none expected", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         flag_field("dot_result", want.dot_result, got.dot_result);
         flag_field("result_index", 32'(want.result_index), 32'(got.result_index));
         flag_field("weight_row", 32'(want.weight_row), 32'(got.weight_row));
         flag_field("saturated", 32'(want.saturated), 32'(got.saturated));
         flag_field("job_done", 32'(want.job_done), 32'(got.job_done));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   qmva_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   qmva_pkg::rsp_type               rsp_data;
   logic                            csr_we = 1'b0;
   logic [qmva_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [qmva_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   matvec_scoreboard sb = new();
   int  cycle_count = 0;
   int  req_gap_odds = 0;
   int  rsp_gap_odds = 0;
   bit  long_hold_req = 1'b0;
   bit  quiet = 1'b0;
   int  random_sent = 0;
   int  gap_choice[3] = '{0, 3, 10};

   quantized_matvec_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("quantized_matvec_accumulator_tb failed");
      $finish;
   end

   // result side: checks each transfer and throttles rsp_ready
   initial begin : rsp_side
      int hold;
      hold = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_gap_odds != 0 && $urandom_range(0, rsp_gap_odds - 1) == 0) begin
            hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   function automatic logic [15:0] pick16();
      if ($urandom_range(0, 7) != 0) return 16'($urandom);
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'h0080;
         default: return 16'h007f;
      endcase
   endfunction

   function automatic qmva_pkg::req_type make_item(logic [15:0] act, logic [15:0] word,
                                                   logic [15:0] scale);
      qmva_pkg::req_type d;
      d.activation = act;
      d.weight_word = word;
      d.weight_scale = scale;
      return d;
   endfunction

   function automatic setup_type make_setup(logic [1:0] fmt, int len, int nb, int start,
                                            int count, int stride, bit scales);
      setup_type s;
      s.fmt = fmt;
      s.in_len = qmva_pkg::IN_LEN_W'(len);
      s.batch_rows = qmva_pkg::BATCH_ROWS_W'(nb);
      s.out_start = qmva_pkg::OUT_START_W'(start);
      s.out_count = qmva_pkg::OUT_COUNT_W'(count);
      s.out_stride = qmva_pkg::OUT_STRIDE_W'(stride);
      s.scales_present = scales;
      return s;
   endfunction

   task automatic csr_put(input logic [qmva_pkg::CSR_IDX_W-1:0] idx,
                          input logic [qmva_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic load_setup(input setup_type s);
      csr_put(qmva_pkg::CSR_WEIGHT_FORMAT, qmva_pkg::CSR_DATA_W'(s.fmt));
      csr_put(qmva_pkg::CSR_IN_LEN, qmva_pkg::CSR_DATA_W'(s.in_len));
      csr_put(qmva_pkg::CSR_BATCH_ROWS, qmva_pkg::CSR_DATA_W'(s.batch_rows));
      csr_put(qmva_pkg::CSR_OUT_START, qmva_pkg::CSR_DATA_W'(s.out_start));
      csr_put(qmva_pkg::CSR_OUT_COUNT, qmva_pkg::CSR_DATA_W'(s.out_count));
      csr_put(qmva_pkg::CSR_OUT_STRIDE, qmva_pkg::CSR_DATA_W'(s.out_stride));
      csr_put(qmva_pkg::CSR_SCALES_PRESENT, qmva_pkg::CSR_DATA_W'(s.scales_present));
      csr_we <= 1'b0;
   endtask

   // valid stays up across back-to-back transfers
   task automatic push_req(input qmva_pkg::req_type d);
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(d);
      if (req_gap_odds != 0 && $urandom_range(0, req_gap_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) push_req(make_item(pick16(), pick16(), pick16()));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      setup_type s;
      int len, count;
      req_gap_odds = quiet ? 0 : gap_choice[$urandom_range(0, 2)];
      rsp_gap_odds = quiet ? 0 : gap_choice[$urandom_range(0, 2)];
      s.fmt = 2'($urandom);
      case ($urandom_range(0, 9))
         0: s.in_len = '0;
         1: s.in_len = qmva_pkg::IN_LEN_W'($urandom_range(9, 80));
         default: s.in_len = qmva_pkg::IN_LEN_W'($urandom_range(1, 8));
      endcase
      s.batch_rows = qmva_pkg::BATCH_ROWS_W'($urandom_range(0, 4));
      s.out_start = qmva_pkg::OUT_START_W'($urandom);
      s.out_count = qmva_pkg::OUT_COUNT_W'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0)
         s.out_stride = qmva_pkg::OUT_STRIDE_W'($urandom_range(0, 2));
      else s.out_stride = qmva_pkg::OUT_STRIDE_W'($urandom);
      s.scales_present = 1'($urandom);
      load_setup(s);
      // whole dot products only, so the next setup lands between them
      len = sb.clamp_count(s.in_len, qmva_pkg::MAX_IN_LEN);
      count = len * $urandom_range(1, (len > 8) ? 2 : 12);
      send_random(count);
      random_sent += count;
      wait_for_results();
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_gap_odds = 4;
      rsp_gap_odds = 4;

      // reset setup: Q4.12 weights, single element, scale ignored; ties round away
      push_req(make_item(16'h7fff, 16'h7fff, 16'h1000));
      push_req(make_item(16'h8000, 16'h8000, 16'h1000));
      push_req(make_item(16'h8000, 16'h7fff, 16'h1000));
      push_req(make_item(16'h0001, 16'h0800, 16'h1000));
      push_req(make_item(16'hffff, 16'h0800, 16'h1000));
      push_req(make_item(16'h0000, 16'hffff, 16'h8000));
      wait_for_results();

      // writes to the unused index do nothing
      csr_put(CSR_UNUSED, 13'h1fff);
      load_setup(make_setup(qmva_pkg::FMT_INT8, 1, 2, 4095, 2, 8191, 1'b1));
      push_req(make_item(16'h8000, 16'h0080, 16'h8000));
      push_req(make_item(16'h7fff, 16'hff7f, 16'h7fff));
      push_req(make_item(16'h3039, 16'h00ff, 16'h0000));
      push_req(make_item(16'hffff, 16'h0001, 16'h7fff));
      wait_for_results();

      load_setup(make_setup(qmva_pkg::FMT_NIB4, 2, 1, 0, 1, 1, 1'b0));
      push_req(make_item(16'h7fff, 16'h00f0, 16'h8000));
      push_req(make_item(16'h8000, 16'h000f, 16'h8000));
      push_req(make_item(16'h1234, 16'hff0f, 16'h8000));
      push_req(make_item(16'hedcb, 16'h00f0, 16'h8000));
      wait_for_results();

      load_setup(make_setup(qmva_pkg::FMT_CRUMB2, 4, 1, 17, 1, 3, 1'b1));
      for (int i = 0; i < 4; i++) push_req(make_item(pick16(), 16'h00e4, 16'hf000));
      wait_for_results();

      // positive then negative clip
      load_setup(make_setup(qmva_pkg::FMT_INT8, 66, 2, 5, 1, 7, 1'b1));
      for (int i = 0; i < 66; i++) push_req(make_item(16'h8000, 16'h0080, 16'h7fff));
      for (int i = 0; i < 66; i++) push_req(make_item(16'h8000, 16'h0080, 16'h8000));
      wait_for_results();

      // lands exactly on the int32 floor without clipping
      load_setup(make_setup(qmva_pkg::FMT_INT8, 64, 1, 0, 1, 1, 1'b1));
      for (int i = 0; i < 64; i++) push_req(make_item(16'h8000, 16'h0080, 16'h8000));
      wait_for_results();

      // batch clamp and index wrap; receiver holds off so the block backs up
      req_gap_odds = 0;
      load_setup(make_setup(qmva_pkg::FMT_NIB4, 1, 511, 4095, 1, 8191, 1'b1));
      long_hold_req = 1'b1;
      send_random(256);
      wait_for_results();
      req_gap_odds = 4;

      // row count clamp, then lowered mid-job so the current row ends the job
      load_setup(make_setup(qmva_pkg::FMT_Q412, 1, 0, 100, 8191, 4096, 1'b0));
      send_random(40);
      wait_for_results();
      load_setup(make_setup(qmva_pkg::FMT_Q412, 1, 0, 100, 2, 4096, 1'b0));
      send_random(3);
      wait_for_results();

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= QUIET_ITEMS) quiet = 1'b1;
         random_phase();
      end
      wait_for_results();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("quantized_matvec_accumulator_tb passed");
      end else begin
         $display("quantized_matvec_accumulator_tb failed");
      end
      $finish;
   end

endmodule
